@@ rtl/lfsr9fs_pkg.sv @@
// shared types, constants and the lfsr step function of the frame scrambler
`default_nettype none

package lfsr9fs_pkg;

    // frame and lfsr geometry
    localparam int          LFSR_W      = 9;
    localparam int          POS_W       = 4;
    localparam int          CNT_W       = 4;
    localparam logic [POS_W-1:0] FRAME_END  = 4'd15;   // no frame open
    localparam logic [POS_W-1:0] FRAME_LAST = 4'd14;   // fifteenth byte
    localparam logic [CNT_W-1:0] LEFT_FULL  = 4'd8;    // a whole byte of leftover bits
    localparam logic [LFSR_W-1:0] SEED_ONES = 9'h1ff;
    localparam int          FB_TAP      = 5;

    // queue between front and back
    localparam int          FIFO_DEPTH  = 2;

    // configuration port
    localparam int          PADDR_W        = 2;
    localparam logic [PADDR_W-1:0] ADDR_DEVICE_ID = 2'd0;

    // one classified item waiting for the back end
    typedef struct packed {
        logic [7:0]        data;
        logic              start;
        logic [LFSR_W-1:0] seed;
    } entry_t;

    // back end state visible to the top level
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [CNT_W-1:0] left_cnt;
    } back_status_t;

    // eight right shifts of x^9+x^5+1, new msb is bit 5 xor bit 0
    function automatic logic [LFSR_W-1:0] next_chunk(input logic [LFSR_W-1:0] r);
        logic [LFSR_W-1:0] v;
        logic              fb;
        v = r;
        for (int i = 0; i < 8; i++) begin
            fb = v[FB_TAP] ^ v[0];
            v  = {fb, v[LFSR_W-1:1]};
        end
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/lfsr9fs_front.sv @@
// front end: takes input transfers, forms the seed and classifies each byte
`default_nettype none

module lfsr9fs_front (
    input  wire logic [23:0]              s_tdata,    // data_byte[7:0], sequence_number[23:8]
    input  wire logic [0:0]               s_tuser,    // start_frame[0]
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [8:0]               device_low,
    input  wire logic                     fifo_full,
    output logic                          push,
    output lfsr9fs_pkg::entry_t           entry
);

    logic [17:0] product;
    logic [8:0]  seed_raw;

    // seed is the low bits of sequence number times device id
    assign product  = {9'd0, s_tdata[16:8]} * {9'd0, device_low};
    assign seed_raw = product[8:0];

    // a zero seed would lock the lfsr, so it becomes all ones
    always_comb begin
        entry.data  = s_tdata[7:0];
        entry.start = s_tuser[0];
        entry.seed  = (seed_raw == 9'd0) ? lfsr9fs_pkg::SEED_ONES : seed_raw;
    end

    // accept whenever the queue has room
    assign s_tready = !fifo_full;
    assign push     = s_tvalid && !fifo_full;

endmodule

`default_nettype wire

@@ rtl/lfsr9fs_fifo.sv @@
// short queue of classified bytes between front and back end
`default_nettype none

module lfsr9fs_fifo #(
    parameter int DEPTH = lfsr9fs_pkg::FIFO_DEPTH
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire lfsr9fs_pkg::entry_t wr_entry,
    output logic                     full,
    input  wire logic                pop,
    output logic                     rd_valid,
    output lfsr9fs_pkg::entry_t      rd_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lfsr9fs_pkg::entry_t slots_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_entry = slots_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && rd_valid;

    // pointer wrap and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage, no reset needed
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

`default_nettype wire

@@ rtl/lfsr9fs_back.sv @@
// back end: keystream state, xor and the output register
`default_nettype none

module lfsr9fs_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    input  wire lfsr9fs_pkg::entry_t  in_entry,
    output logic                      pop,
    output logic [7:0]                m_tdata,    // result_byte[7:0]
    output logic                      m_tlast,    // last_byte
    output logic [0:0]                m_tuser,    // beyond_frame[0]
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output lfsr9fs_pkg::back_status_t status
);

    localparam int LW = lfsr9fs_pkg::LFSR_W;
    localparam int PW = lfsr9fs_pkg::POS_W;
    localparam int CW = lfsr9fs_pkg::CNT_W;

    logic [LW-1:0] lfsr_reg, lfsr_next;
    logic [7:0]    left_bits_reg, left_bits_next;
    logic [CW-1:0] left_cnt_reg, left_cnt_next;
    logic [PW-1:0] pos_reg, pos_next;

    logic          m_valid_reg;
    logic [7:0]    m_data_reg, m_data_next;
    logic          m_last_reg, m_last_next;
    logic          m_beyond_reg, m_beyond_next;

    logic [LW-1:0] cur_lfsr;
    logic [7:0]    cur_bits;
    logic [CW-1:0] cur_cnt;
    logic [PW-1:0] cur_pos;
    logic [LW-1:0] chunk;
    logic [16:0]   combined;
    logic [CW-1:0] shamt;
    logic [7:0]    keep_mask;
    logic [7:0]    key;

    // take an item when the output register is empty or being drained
    assign pop = in_valid && (!m_valid_reg || m_tready);

    // a start byte reseeds and opens a new frame
    always_comb begin
        if (in_entry.start) begin
            cur_lfsr = in_entry.seed;
            cur_bits = '0;
            cur_cnt  = '0;
            cur_pos  = '0;
        end else begin
            cur_lfsr = lfsr_reg;
            cur_bits = left_bits_reg;
            cur_cnt  = left_cnt_reg;
            cur_pos  = pos_reg;
        end
    end

    // next chunk joined below the leftover bits, msb first
    assign chunk     = lfsr9fs_pkg::next_chunk(cur_lfsr);
    assign combined  = {cur_bits, chunk};
    assign shamt     = cur_cnt + 1'b1;
    assign keep_mask = 8'((9'd1 << shamt) - 9'd1);

    // keystream byte and state update
    always_comb begin
        lfsr_next      = lfsr_reg;
        left_bits_next = left_bits_reg;
        left_cnt_next  = left_cnt_reg;
        pos_next       = pos_reg;
        key            = '0;
        m_data_next    = in_entry.data;
        m_last_next    = 1'b0;
        m_beyond_next  = 1'b1;
        if (cur_pos != lfsr9fs_pkg::FRAME_END) begin
            if (cur_cnt >= lfsr9fs_pkg::LEFT_FULL) begin
                key            = cur_bits;
                lfsr_next      = cur_lfsr;
                left_bits_next = '0;
                left_cnt_next  = '0;
            end else begin
                key            = 8'(combined >> shamt);
                lfsr_next      = chunk;
                left_bits_next = combined[7:0] & keep_mask;
                left_cnt_next  = shamt;
            end
            pos_next      = cur_pos + 1'b1;
            m_data_next   = in_entry.data ^ key;
            m_last_next   = (cur_pos == lfsr9fs_pkg::FRAME_LAST);
            m_beyond_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lfsr_reg      <= lfsr9fs_pkg::SEED_ONES;
            left_bits_reg <= '0;
            left_cnt_reg  <= '0;
            pos_reg       <= lfsr9fs_pkg::FRAME_END;
            m_valid_reg   <= 1'b0;
        end else begin
            if (pop) begin
                lfsr_reg      <= lfsr_next;
                left_bits_reg <= left_bits_next;
                left_cnt_reg  <= left_cnt_next;
                pos_reg       <= pos_next;
                m_valid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg   <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            m_data_reg   <= m_data_next;
            m_last_reg   <= m_last_next;
            m_beyond_reg <= m_beyond_next;
        end
    end

    assign m_tvalid        = m_valid_reg;
    assign m_tdata         = m_data_reg;
    assign m_tlast         = m_last_reg;
    assign m_tuser         = m_beyond_reg;
    assign status.pos      = pos_reg;
    assign status.left_cnt = left_cnt_reg;

endmodule

`default_nettype wire

@@ rtl/lfsr9_frame_scrambler.sv @@
// top level of the lfsr9 frame scrambler: register port, front, queue, back
//
// Scrambles or descrambles a 15-byte frame one byte per transfer; the same
// operation does both. Input stream s_*: tdata carries the byte and the
// 16-bit sequence number, tuser[0] marks the first byte of a frame and
// reseeds the 9-bit LFSR from sequence number times device id. Output
// stream m_*: tdata is the byte xor keystream, tlast marks the fifteenth
// byte, tuser[0] flags a byte outside an open frame that passed unchanged.
// The device id register sits at APB address 0; write it only while idle.
// An input transfer passes through the queue and the output register before
// it leaves as an output transfer. Throughput is one byte per cycle while
// m_tready stays high: the LFSR step for a whole byte is a fixed xor network
// in the back end, and the queue plus output register keep both sides moving.
// When the receiver stalls, the output register holds, the queue fills
// (FIFO_DEPTH entries) and then s_tready drops.
// Reset empties the queue and output, sets the LFSR to all ones, closes any
// frame and clears the device id.
`default_nettype none

module lfsr9_frame_scrambler #(
    parameter int FIFO_DEPTH = lfsr9fs_pkg::FIFO_DEPTH
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [lfsr9fs_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    // input stream
    input  wire logic [23:0]                     s_tdata,  // data_byte[7:0], sequence_number[23:8]
    input  wire logic [0:0]                      s_tuser,  // start_frame[0]
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // output stream
    output logic [7:0]                           m_tdata,  // result_byte[7:0]
    output logic                                 m_tlast,  // last_byte
    output logic [0:0]                           m_tuser,  // beyond_frame[0]
    output logic                                 m_tvalid,
    input  wire logic                            m_tready
);

    logic [31:0]               device_id_reg, device_id_next;
    logic                      cfg_write;
    logic                      push;
    logic                      fifo_full;
    logic                      fifo_valid;
    logic                      pop;
    lfsr9fs_pkg::entry_t       wr_entry;
    lfsr9fs_pkg::entry_t       rd_entry;
    lfsr9fs_pkg::back_status_t back_status;

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        device_id_next = device_id_reg;
        if (cfg_write && (paddr == lfsr9fs_pkg::ADDR_DEVICE_ID)) begin
            device_id_next = pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_id_reg <= '0;
        end else begin
            device_id_reg <= device_id_next;
        end
    end

    assign prdata = (paddr == lfsr9fs_pkg::ADDR_DEVICE_ID) ? device_id_reg : 32'd0;

    // front end
    lfsr9fs_front u_front (
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .device_low (device_id_reg[8:0]),
        .fifo_full  (fifo_full),
        .push       (push),
        .entry      (wr_entry)
    );

    // queue
    lfsr9fs_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .wr_entry (wr_entry),
        .full     (fifo_full),
        .pop      (pop),
        .rd_valid (fifo_valid),
        .rd_entry (rd_entry)
    );

    // back end
    lfsr9fs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (fifo_valid),
        .in_entry (rd_entry),
        .pop      (pop),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (back_status)
    );

    // leftover keystream never holds more than one byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        back_status.left_cnt <= lfsr9fs_pkg::LEFT_FULL)
        else $error("leftover count above one byte");

    // a passed-through byte never closes a frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> !m_tlast)
        else $error("beyond-frame byte flagged as last");

    // a byte flagged last leaves the frame closed
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop && !rd_entry.start && (back_status.pos == lfsr9fs_pkg::FRAME_LAST)
        |=> (back_status.pos == lfsr9fs_pkg::FRAME_END) && m_tlast)
        else $error("frame not closed after fifteenth byte");

    // output is empty right after reset
    assert property (@(posedge aclk)
        $past(!aresetn) && aresetn |-> !m_tvalid)
        else $error("output valid straight after reset");

endmodule

`default_nettype wire
